// ===== design/ctp_pkg.sv =====
// Shared types and constants of the cooking timer pause controller.
package ctp_pkg;

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_COOK  = 3'd1;
    localparam logic [2:0] PH_WAIT  = 3'd2;
    localparam logic [2:0] PH_PAUSE = 3'd3;
    localparam logic [2:0] PH_ALERT = 3'd4;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    localparam logic [12:0] MAX_START   = 13'd5999;
    localparam logic [13:0] RECIP_60    = 14'd8739;
    localparam logic [5:0]  LAST_SECOND = 6'd59;

    typedef struct packed {
        logic        op;
        logic [12:0] start_seconds;
        logic        stop_pressed;
        logic        resume_pressed;
        logic        door_closed;
    } t_in_item;

    typedef struct packed {
        logic [2:0] phase;
        logic       lamp_on;
        logic       buzzer_on;
        logic [6:0] minutes_left;
        logic [5:0] seconds_left;
        logic       cook_done;
        logic       cook_cancelled;
    } t_out_item;

endpackage

// ===== design/ctp_core.sv =====
// Controller state and the next-state logic for one item.
module ctp_core #(
    parameter int TICKS_PER_SECOND = 100,
    parameter int ALERT_SLOTS      = 6
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  ctp_pkg::t_in_item  i_item,
    output ctp_pkg::t_out_item o_result
);
    import ctp_pkg::*;

    localparam int TW = $clog2(TICKS_PER_SECOND);
    localparam int SW = $clog2(ALERT_SLOTS + 1);

    logic [2:0]    r_phase, n_phase;
    logic [6:0]    r_min, n_min;
    logic [5:0]    r_sec, n_sec;
    logic [TW-1:0] r_tick, n_tick;
    logic [TW-1:0] r_pause, n_pause;
    logic [SW-1:0] r_slots, n_slots;
    logic          r_lamp, n_lamp;
    logic          r_buzzer, n_buzzer;

    logic          done;
    logic          cancel;
    logic          do_advance;
    logic [TW:0]   tick_inc;
    logic          tick_wrap;
    logic [TW:0]   pause_inc;
    logic          pause_wrap;
    logic [SW-1:0] slot_inc;
    logic [6:0]    dec_min;
    logic [5:0]    dec_sec;
    logic          dec_zero;
    logic [12:0]   secs_sat;
    logic [25:0]   prod;
    logic [6:0]    start_min;
    logic [12:0]   start_rem;

    assign tick_inc   = {1'b0, r_tick} + (TW + 1)'(1);
    assign tick_wrap  = tick_inc >= (TW + 1)'(TICKS_PER_SECOND);
    assign pause_inc  = {1'b0, r_pause} + (TW + 1)'(1);
    assign pause_wrap = pause_inc >= (TW + 1)'(TICKS_PER_SECOND);
    assign slot_inc   = r_slots + SW'(1);

    assign dec_sec  = (r_sec == 6'd0) ? LAST_SECOND : r_sec - 6'd1;
    assign dec_min  = (r_sec == 6'd0) ? r_min - 7'd1 : r_min;
    assign dec_zero = (r_min == 7'd0) && (r_sec <= 6'd1);

    // Split of the start time into minutes and seconds by a reciprocal of 60.
    assign secs_sat  = (i_item.start_seconds > MAX_START) ? MAX_START : i_item.start_seconds;
    assign prod      = 26'(secs_sat) * 26'(RECIP_60);
    assign start_min = prod[25:19];
    assign start_rem = secs_sat - (13'({start_min, 6'b0}) - 13'({start_min, 2'b0}));

    always_comb begin
        n_phase    = r_phase;
        n_min      = r_min;
        n_sec      = r_sec;
        n_tick     = r_tick;
        n_pause    = r_pause;
        n_slots    = r_slots;
        n_lamp     = r_lamp;
        n_buzzer   = r_buzzer;
        done       = 1'b0;
        cancel     = 1'b0;
        do_advance = 1'b0;

        if (i_item.op == OP_START) begin
            if (r_phase == PH_IDLE) begin
                n_min    = start_min;
                n_sec    = start_rem[5:0];
                n_tick   = '0;
                n_pause  = '0;
                n_lamp   = 1'b1;
                n_buzzer = 1'b0;
                if (secs_sat == 13'd0) begin
                    n_phase  = PH_ALERT;
                    n_slots  = '0;
                    n_lamp   = 1'b0;
                    done     = 1'b1;
                end else begin
                    n_phase = PH_COOK;
                end
            end
        end else begin
            unique case (r_phase) inside
                PH_COOK: begin
                    if (i_item.stop_pressed || !i_item.door_closed) begin
                        n_pause = '0;
                        n_phase = i_item.stop_pressed ? PH_WAIT : PH_PAUSE;
                    end else begin
                        do_advance = 1'b1;
                    end
                end
                PH_WAIT, PH_PAUSE: begin
                    if (r_phase == PH_PAUSE || !i_item.stop_pressed) begin
                        if (i_item.resume_pressed && i_item.door_closed) begin
                            n_phase    = PH_COOK;
                            n_lamp     = 1'b1;
                            do_advance = 1'b1;
                        end else if (i_item.stop_pressed) begin
                            n_phase = PH_IDLE;
                            n_lamp  = 1'b0;
                            n_min   = '0;
                            n_sec   = '0;
                            n_tick  = '0;
                            n_pause = '0;
                            cancel  = 1'b1;
                        end else begin
                            n_phase = PH_PAUSE;
                            if (pause_wrap) begin
                                n_pause = '0;
                                n_lamp  = ~r_lamp;
                            end else begin
                                n_pause = pause_inc[TW-1:0];
                            end
                        end
                    end
                end
                PH_ALERT: begin
                    if (tick_wrap) begin
                        n_tick = '0;
                        if (slot_inc >= SW'(ALERT_SLOTS)) begin
                            n_slots  = '0;
                            n_lamp   = 1'b0;
                            n_buzzer = 1'b0;
                            n_phase  = PH_IDLE;
                        end else begin
                            n_slots  = slot_inc;
                            n_lamp   = ~r_lamp;
                            n_buzzer = ~r_buzzer;
                        end
                    end else begin
                        n_tick = tick_inc[TW-1:0];
                    end
                end
                default: begin
                end
            endcase
        end

        if (do_advance) begin
            if (tick_wrap) begin
                n_tick = '0;
                if (dec_zero) begin
                    n_phase  = PH_ALERT;
                    n_min    = '0;
                    n_sec    = '0;
                    n_slots  = '0;
                    n_lamp   = 1'b0;
                    n_buzzer = 1'b0;
                    done     = 1'b1;
                end else begin
                    n_min = dec_min;
                    n_sec = dec_sec;
                end
            end else begin
                n_tick = tick_inc[TW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_min    <= '0;
            r_sec    <= '0;
            r_tick   <= '0;
            r_pause  <= '0;
            r_slots  <= '0;
            r_lamp   <= 1'b0;
            r_buzzer <= 1'b0;
        end else if (i_fire) begin
            r_phase  <= n_phase;
            r_min    <= n_min;
            r_sec    <= n_sec;
            r_tick   <= n_tick;
            r_pause  <= n_pause;
            r_slots  <= n_slots;
            r_lamp   <= n_lamp;
            r_buzzer <= n_buzzer;
        end
    end

    always_comb begin
        o_result.phase          = n_phase;
        o_result.lamp_on        = n_lamp;
        o_result.buzzer_on      = n_buzzer;
        o_result.minutes_left   = n_min;
        o_result.seconds_left   = n_sec;
        o_result.cook_done      = done;
        o_result.cook_cancelled = cancel;
    end

`ifndef SYNTHESIS
    a_done_enters_alert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && done |=> r_phase == PH_ALERT && r_min == 7'd0 && r_sec == 6'd0)
        else $error("countdown completion did not enter the alert phase");

    a_cancel_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && cancel |=> r_phase == PH_IDLE && !r_lamp && r_min == 7'd0)
        else $error("cancel did not return to idle with the lamp off");

    a_buzzer_alert_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_buzzer |-> r_phase == PH_ALERT)
        else $error("buzzer driven outside the alert phase");

    a_seconds_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sec <= LAST_SECOND)
        else $error("seconds count out of range");

    a_cook_time_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_COOK |-> r_min != 7'd0 || r_sec != 6'd0)
        else $error("cooking with no time left");
`endif

endmodule

// ===== design/cook_timer_pause_controller_unit.sv =====
// Top level of the cooking timer pause controller with its transfer registers.
//
// Usage: each input transfer carries one item, either a 10 ms tick with the
// button and door samples or a start command with the cooking time in
// seconds. Every item gives exactly one result transfer with the phase, lamp
// and buzzer drive, the remaining minutes and seconds and the done and
// cancel pulses.
// An accepted item is held in the input register, and the next-state logic
// runs from it into the result register, which offers it to the receiver.
// One item is taken in every cycle unless both registers are full and the
// receiver stalls; the state update is a single pass of logic fed by the
// input register.
// While the receiver stalls, the result register holds its payload and the
// input register holds the next item; further input is stalled only once
// both are full.
// Reset is synchronous and active low: it empties both registers and puts
// the controller in idle with the lamp and buzzer off and no time left.
module cook_timer_pause_controller_unit #(
    parameter int TICKS_PER_SECOND = 100,
    parameter int ALERT_SLOTS      = 6
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  ctp_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ctp_pkg::t_out_item o_out_item
);
    import ctp_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;

    logic      out_busy;
    logic      fire;
    logic      accept_in;
    t_out_item result;

    assign out_busy   = r_out_valid && i_out_stall;
    assign fire       = r_in_valid && !out_busy;
    assign o_in_stall = r_in_valid && out_busy;
    assign accept_in  = i_in_valid && !o_in_stall;

    ctp_core #(
        .TICKS_PER_SECOND(TICKS_PER_SECOND),
        .ALERT_SLOTS     (ALERT_SLOTS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_item  (r_in),
        .o_result(result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept_in) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (!out_busy) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_in <= i_in_item;
        end
        if (fire) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule
